@@ rtl/core/qau_pkg.sv @@
`default_nettype none

package qau_pkg;

    localparam int QFB              = 30;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam logic [31:0] RATE_SCALE_RST = 32'd216931;

    localparam int ACC_W    = 64;
    localparam int OPND_W   = 33;
    localparam int CORD_W   = 40;
    localparam int ANGLE_W  = 16;
    localparam int H_SH     = 33 - QFB;
    localparam int MAT_SH   = 2 * QFB - 30;
    localparam int DIV_BITS = QFB + 1;
    localparam int ATAN_N   = 30;

    localparam logic [3:0] OP_Q0 = 4'd0;
    localparam logic [3:0] OP_Q1 = 4'd1;
    localparam logic [3:0] OP_Q2 = 4'd2;
    localparam logic [3:0] OP_Q3 = 4'd3;
    localparam logic [3:0] OP_H0 = 4'd4;
    localparam logic [3:0] OP_H1 = 4'd5;
    localparam logic [3:0] OP_H2 = 4'd6;
    localparam logic [3:0] OP_P0 = 4'd7;
    localparam logic [3:0] OP_P1 = 4'd8;
    localparam logic [3:0] OP_P2 = 4'd9;
    localparam logic [3:0] OP_P3 = 4'd10;
    localparam logic [3:0] OP_T13 = 4'd11;
    localparam logic [3:0] OP_GX = 4'd12;
    localparam logic [3:0] OP_GY = 4'd13;
    localparam logic [3:0] OP_GZ = 4'd14;
    localparam logic [3:0] OP_RS = 4'd15;

    localparam logic [5:0] U_H_BEG   = 6'd0;
    localparam logic [5:0] U_H_END   = 6'd2;
    localparam logic [5:0] U_UPD_BEG = 6'd3;
    localparam logic [5:0] U_UPD_END = 6'd14;
    localparam logic [5:0] U_SQR_BEG = 6'd15;
    localparam logic [5:0] U_SQR_END = 6'd18;
    localparam logic [5:0] U_MAT_BEG = 6'd19;
    localparam logic [5:0] U_MAT_END = 6'd32;
    localparam logic [5:0] U_T13     = 6'd33;

    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [2:0] dst;
        logic       neg;
    } uop_t;

    function automatic uop_t uop(input logic [5:0] idx);
        uop_t u;
        u = '{a: OP_Q0, b: OP_Q0, dst: 3'd0, neg: 1'b0};
        unique case (idx)
            6'd0:  u = '{a: OP_GX, b: OP_RS, dst: 3'd0, neg: 1'b0};
            6'd1:  u = '{a: OP_GY, b: OP_RS, dst: 3'd1, neg: 1'b0};
            6'd2:  u = '{a: OP_GZ, b: OP_RS, dst: 3'd2, neg: 1'b0};
            6'd3:  u = '{a: OP_Q1, b: OP_H0, dst: 3'd0, neg: 1'b1};
            6'd4:  u = '{a: OP_Q2, b: OP_H1, dst: 3'd0, neg: 1'b1};
            6'd5:  u = '{a: OP_Q3, b: OP_H2, dst: 3'd0, neg: 1'b1};
            6'd6:  u = '{a: OP_Q0, b: OP_H0, dst: 3'd1, neg: 1'b0};
            6'd7:  u = '{a: OP_Q2, b: OP_H2, dst: 3'd1, neg: 1'b0};
            6'd8:  u = '{a: OP_Q3, b: OP_H1, dst: 3'd1, neg: 1'b1};
            6'd9:  u = '{a: OP_Q0, b: OP_H1, dst: 3'd2, neg: 1'b0};
            6'd10: u = '{a: OP_Q1, b: OP_H2, dst: 3'd2, neg: 1'b1};
            6'd11: u = '{a: OP_Q3, b: OP_H0, dst: 3'd2, neg: 1'b0};
            6'd12: u = '{a: OP_Q0, b: OP_H2, dst: 3'd3, neg: 1'b0};
            6'd13: u = '{a: OP_Q1, b: OP_H1, dst: 3'd3, neg: 1'b0};
            6'd14: u = '{a: OP_Q2, b: OP_H0, dst: 3'd3, neg: 1'b1};
            6'd15: u = '{a: OP_P0, b: OP_P0, dst: 3'd4, neg: 1'b0};
            6'd16: u = '{a: OP_P1, b: OP_P1, dst: 3'd4, neg: 1'b0};
            6'd17: u = '{a: OP_P2, b: OP_P2, dst: 3'd4, neg: 1'b0};
            6'd18: u = '{a: OP_P3, b: OP_P3, dst: 3'd4, neg: 1'b0};
            6'd19: u = '{a: OP_Q0, b: OP_Q0, dst: 3'd0, neg: 1'b0};
            6'd20: u = '{a: OP_Q1, b: OP_Q1, dst: 3'd0, neg: 1'b0};
            6'd21: u = '{a: OP_Q2, b: OP_Q2, dst: 3'd0, neg: 1'b1};
            6'd22: u = '{a: OP_Q3, b: OP_Q3, dst: 3'd0, neg: 1'b1};
            6'd23: u = '{a: OP_Q1, b: OP_Q2, dst: 3'd1, neg: 1'b0};
            6'd24: u = '{a: OP_Q0, b: OP_Q3, dst: 3'd1, neg: 1'b0};
            6'd25: u = '{a: OP_Q1, b: OP_Q3, dst: 3'd2, neg: 1'b0};
            6'd26: u = '{a: OP_Q0, b: OP_Q2, dst: 3'd2, neg: 1'b1};
            6'd27: u = '{a: OP_Q2, b: OP_Q3, dst: 3'd3, neg: 1'b0};
            6'd28: u = '{a: OP_Q0, b: OP_Q1, dst: 3'd3, neg: 1'b0};
            6'd29: u = '{a: OP_Q0, b: OP_Q0, dst: 3'd4, neg: 1'b0};
            6'd30: u = '{a: OP_Q1, b: OP_Q1, dst: 3'd4, neg: 1'b1};
            6'd31: u = '{a: OP_Q2, b: OP_Q2, dst: 3'd4, neg: 1'b1};
            6'd32: u = '{a: OP_Q3, b: OP_Q3, dst: 3'd4, neg: 1'b0};
            6'd33: u = '{a: OP_T13, b: OP_T13, dst: 3'd0, neg: 1'b0};
            default: u = '{a: OP_Q0, b: OP_Q0, dst: 3'd0, neg: 1'b0};
        endcase
        return u;
    endfunction

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        v = 32'd0;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/qau_mul.sv @@
`default_nettype none

module qau_mul (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [qau_pkg::OPND_W-1:0] a,
    input  wire logic signed [qau_pkg::OPND_W-1:0] b,
    output logic signed [qau_pkg::ACC_W-1:0]       prod
);

    logic signed [2*qau_pkg::OPND_W-1:0] full;
    logic signed [qau_pkg::ACC_W-1:0]    prod_reg;

    assign full = a * b;
    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= full[qau_pkg::ACC_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/qau_sqrt.sv @@
`default_nettype none

module qau_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] value,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] bit_val;
    logic [64:0] trial;

    assign bit_val = 64'd1 << {cnt_reg, 1'b0};
    assign trial   = {1'b0, r_reg} + {1'b0, bit_val};
    assign done    = done_reg;
    assign root    = r_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            r_reg   <= 64'd0;
            cnt_reg <= 5'd31;
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_reg <= v_reg - trial[63:0];
                r_reg <= (r_reg >> 1) + bit_val;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/qau_div.sv @@
`default_nettype none

module qau_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [63:0]                   num,
    input  wire logic [32:0]                   den,
    output logic                               done,
    output logic [qau_pkg::DIV_BITS-1:0]       quo
);

    localparam int CW = $clog2(qau_pkg::DIV_BITS);

    logic [63:0]                   rem_reg;
    logic [63:0]                   dsh_reg;
    logic [qau_pkg::DIV_BITS-1:0]  quo_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= 64'(den) << (qau_pkg::DIV_BITS - 1);
            quo_reg <= '0;
            cnt_reg <= CW'(qau_pkg::DIV_BITS - 1);
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[qau_pkg::DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[qau_pkg::DIV_BITS-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/qau_cordic.sv @@
`default_nettype none

module qau_cordic #(
    parameter int CORDIC_STEPS = qau_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [qau_pkg::CORD_W-1:0]  x_in,
    input  wire logic signed [qau_pkg::CORD_W-1:0]  y_in,
    output logic                                    done,
    output logic signed [qau_pkg::ANGLE_W-1:0]      angle
);

    localparam int NSTEP = (CORDIC_STEPS < qau_pkg::ATAN_N) ? CORDIC_STEPS : qau_pkg::ATAN_N;

    logic signed [qau_pkg::CORD_W-1:0] x_reg;
    logic signed [qau_pkg::CORD_W-1:0] y_reg;
    logic [31:0]                       z_reg;
    logic [4:0]                        i_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic signed [qau_pkg::ANGLE_W-1:0] angle_reg;

    logic signed [qau_pkg::CORD_W-1:0] xs;
    logic signed [qau_pkg::CORD_W-1:0] ys;
    logic [31:0]                       z_next;
    logic [31:0]                       z_rnd;
    logic                              rot_pos;

    assign xs      = x_reg >>> i_reg;
    assign ys      = y_reg >>> i_reg;
    assign rot_pos = y_reg > 0;
    assign z_next  = rot_pos ? z_reg + qau_pkg::atan_entry(i_reg)
                             : z_reg - qau_pkg::atan_entry(i_reg);
    assign z_rnd   = z_next + 32'h0000_8000;
    assign done    = done_reg;
    assign angle   = angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (x_in == '0 && y_in == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg && i_reg == 5'(NSTEP - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            i_reg     <= 5'd0;
            angle_reg <= '0;
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg <= y_in;
                    y_reg <= -x_in;
                    z_reg <= 32'h4000_0000;
                end
                else
                begin
                    x_reg <= -y_in;
                    y_reg <= x_in;
                    z_reg <= 32'hC000_0000;
                end
            end
            else
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= 32'd0;
            end
        end
        else if (busy_reg)
        begin
            if (rot_pos)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
            end
            z_reg     <= z_next;
            i_reg     <= i_reg + 5'd1;
            angle_reg <= z_rnd[31:16];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/quaternion_attitude_update.sv @@
`default_nettype none

// First-order quaternion attitude integrator with roll, pitch and yaw readout.
// Each gyro beat is scaled by rate_scale, applied to the stored Q2.30
// quaternion, renormalized, and turned into binary angles (32768 = pi).
// Per beat, a single shared multiplier runs 34 products, a bit-serial square
// root runs twice, a bit-serial divider runs four times, and one CORDIC unit
// runs three angles. No new beat is taken until the current one has finished;
// a finished result sits in the output register while the next beat is taken.
// rate_scale must be written only while the block is idle.
module quaternion_attitude_update #(
    parameter int CORDIC_STEPS = qau_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rate_scale_we,
    input  wire logic [31:0]        rate_scale_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] gyro_x,
    input  wire logic signed [15:0] gyro_y,
    input  wire logic signed [15:0] gyro_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      quat_w,
    output logic signed [31:0]      quat_x,
    output logic signed [31:0]      quat_y,
    output logic signed [31:0]      quat_z,
    output logic signed [15:0]      roll_angle,
    output logic signed [15:0]      pitch_angle,
    output logic signed [15:0]      yaw_angle
);

    localparam int AW = qau_pkg::ACC_W;
    localparam int OW = qau_pkg::OPND_W;
    localparam int CW = qau_pkg::CORD_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_FLUSH  = 4'd2;
    localparam logic [3:0] S_POST   = 4'd3;
    localparam logic [3:0] S_SQRT   = 4'd4;
    localparam logic [3:0] S_DIVGO  = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_CORDGO = 4'd7;
    localparam logic [3:0] S_CORD   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    localparam logic [2:0] SEG_H   = 3'd0;
    localparam logic [2:0] SEG_UPD = 3'd1;
    localparam logic [2:0] SEG_SQR = 3'd2;
    localparam logic [2:0] SEG_MAT = 3'd3;
    localparam logic [2:0] SEG_T13 = 3'd4;

    localparam logic signed [AW-1:0] ONE   = AW'(64'sd1 <<< qau_pkg::QFB);
    localparam logic signed [AW-1:0] M_ONE = AW'(64'sd1 <<< 30);
    localparam logic signed [AW-1:0] P_LIM = AW'(64'sd2147483647);
    localparam logic [63:0]          M_ONE_SQ = 64'd1 << 60;

    typedef struct packed {
        logic       valid;
        logic [2:0] dst;
        logic       neg;
    } pend_t;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic [2:0]  seg_reg;
    logic [5:0]  uidx_reg;
    logic [1:0]  kidx_reg;
    logic        asin_reg;
    pend_t       pend_reg;

    logic [31:0]        rate_scale_reg;
    logic signed [15:0] g_reg [3];
    logic signed [31:0] q_reg [4];
    logic signed [31:0] h_reg [3];
    logic signed [31:0] p_reg [4];
    logic signed [AW-1:0] acc_reg [5];
    logic [31:0]        n_reg;
    logic signed [CW-1:0] t11_reg;
    logic signed [CW-1:0] t12_reg;
    logic signed [CW-1:0] t23_reg;
    logic signed [CW-1:0] t33_reg;
    logic signed [31:0] t13_reg;
    logic [31:0]        s2_reg;
    logic signed [15:0] yaw_reg;
    logic signed [15:0] roll_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_q_reg [4];
    logic signed [15:0] out_roll_reg;
    logic signed [15:0] out_pitch_reg;
    logic signed [15:0] out_yaw_reg;

    qau_pkg::uop_t      u;
    logic signed [OW-1:0] opnd [16];
    logic signed [AW-1:0] prod;
    logic signed [AW-1:0] acc_sum;
    logic               accept;
    logic               out_load;

    logic               sqrt_start;
    logic [63:0]        sqrt_value;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;

    logic               div_start;
    logic [63:0]        div_num;
    logic [32:0]        div_den;
    logic               div_done;
    logic [qau_pkg::DIV_BITS-1:0] div_quo;
    logic [31:0]        p_mag;

    logic               cord_start;
    logic signed [CW-1:0] cord_x;
    logic signed [CW-1:0] cord_y;
    logic               cord_done;
    logic signed [15:0] cord_angle;
    logic signed [16:0] pitch_neg;

    function automatic logic signed [31:0] clamp_h(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (qau_pkg::H_SH - 1))) >>> qau_pkg::H_SH;
        if (t > ONE)
        begin
            t = ONE;
        end
        else if (t < -ONE)
        begin
            t = -ONE;
        end
        return t[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_p(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (qau_pkg::QFB - 1))) >>> qau_pkg::QFB;
        if (t > P_LIM)
        begin
            t = P_LIM;
        end
        else if (t < -P_LIM)
        begin
            t = -P_LIM;
        end
        return t[31:0];
    endfunction

    function automatic logic signed [CW-1:0] rnd_mat(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (qau_pkg::MAT_SH - 1))) >>> qau_pkg::MAT_SH;
        return t[CW-1:0];
    endfunction

    function automatic logic signed [31:0] norm_q(input logic [qau_pkg::DIV_BITS-1:0] v,
                                                  input logic neg);
        logic signed [63:0] t;
        t = $signed(64'(v));
        if (t > ONE)
        begin
            t = ONE;
        end
        if (neg)
        begin
            t = -t;
        end
        return t[31:0];
    endfunction

    assign u      = qau_pkg::uop(uidx_reg);
    assign accept = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign out_load = state_reg == S_DONE && (!out_valid_reg || !out_stall);

    always_comb
    begin
        opnd[qau_pkg::OP_Q0]  = OW'(q_reg[0]);
        opnd[qau_pkg::OP_Q1]  = OW'(q_reg[1]);
        opnd[qau_pkg::OP_Q2]  = OW'(q_reg[2]);
        opnd[qau_pkg::OP_Q3]  = OW'(q_reg[3]);
        opnd[qau_pkg::OP_H0]  = OW'(h_reg[0]);
        opnd[qau_pkg::OP_H1]  = OW'(h_reg[1]);
        opnd[qau_pkg::OP_H2]  = OW'(h_reg[2]);
        opnd[qau_pkg::OP_P0]  = OW'(p_reg[0]);
        opnd[qau_pkg::OP_P1]  = OW'(p_reg[1]);
        opnd[qau_pkg::OP_P2]  = OW'(p_reg[2]);
        opnd[qau_pkg::OP_P3]  = OW'(p_reg[3]);
        opnd[qau_pkg::OP_T13] = OW'(t13_reg);
        opnd[qau_pkg::OP_GX]  = OW'(g_reg[0]);
        opnd[qau_pkg::OP_GY]  = OW'(g_reg[1]);
        opnd[qau_pkg::OP_GZ]  = OW'(g_reg[2]);
        opnd[qau_pkg::OP_RS]  = $signed({1'b0, rate_scale_reg});
    end

    qau_mul u_mul (
        .clk  (clk),
        .en   (state_reg == S_MUL),
        .a    (opnd[u.a]),
        .b    (opnd[u.b]),
        .prod (prod)
    );

    assign acc_sum = pend_reg.neg ? acc_reg[pend_reg.dst] - prod
                                  : acc_reg[pend_reg.dst] + prod;

    // square root of the norm sum or of one minus t13 squared
    assign sqrt_start = state_reg == S_POST && (seg_reg == SEG_SQR || seg_reg == SEG_T13);
    assign sqrt_value = (seg_reg == SEG_SQR) ? acc_reg[4] : M_ONE_SQ - acc_reg[0];

    qau_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (sqrt_value),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign p_mag     = p_reg[kidx_reg][31] ? 32'(-p_reg[kidx_reg]) : 32'(p_reg[kidx_reg]);
    assign div_start = state_reg == S_DIVGO;
    assign div_num   = (64'(p_mag) << (qau_pkg::QFB + 1)) + 64'(n_reg);
    assign div_den   = {1'b0, n_reg} << 1;

    qau_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign cord_start = state_reg == S_CORDGO;

    always_comb
    begin
        unique case (kidx_reg)
            2'd0:
            begin
                cord_x = t11_reg;
                cord_y = t12_reg;
            end
            2'd1:
            begin
                cord_x = t33_reg;
                cord_y = t23_reg;
            end
            default:
            begin
                cord_x = CW'($signed({1'b0, s2_reg}));
                cord_y = CW'(t13_reg);
            end
        endcase
    end

    qau_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .x_in  (cord_x),
        .y_in  (cord_y),
        .done  (cord_done),
        .angle (cord_angle)
    );

    assign pitch_neg = -17'(cord_angle);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if ((seg_reg == SEG_H && uidx_reg == qau_pkg::U_H_END)
                    || (seg_reg == SEG_UPD && uidx_reg == qau_pkg::U_UPD_END)
                    || (seg_reg == SEG_SQR && uidx_reg == qau_pkg::U_SQR_END)
                    || (seg_reg == SEG_MAT && uidx_reg == qau_pkg::U_MAT_END)
                    || seg_reg == SEG_T13)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_POST;
            end
            S_POST:
            begin
                if (seg_reg == SEG_SQR || seg_reg == SEG_T13)
                begin
                    state_next = S_SQRT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    if (asin_reg)
                    begin
                        state_next = S_CORDGO;
                    end
                    else if (sqrt_root == 32'd0)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_DIVGO;
                    end
                end
            end
            S_DIVGO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = (kidx_reg == 2'd3) ? S_MUL : S_DIVGO;
                end
            end
            S_CORDGO:
            begin
                state_next = S_CORD;
            end
            S_CORD:
            begin
                if (cord_done)
                begin
                    state_next = (kidx_reg == 2'd2) ? S_DONE : S_CORDGO;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rate_scale_reg <= qau_pkg::RATE_SCALE_RST;
            q_reg[0]       <= ONE[31:0];
            q_reg[1]       <= 32'sd0;
            q_reg[2]       <= 32'sd0;
            q_reg[3]       <= 32'sd0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= '{valid: state_reg == S_MUL, dst: u.dst, neg: u.neg};
            if (rate_scale_we)
            begin
                rate_scale_reg <= rate_scale_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_SQRT && sqrt_done && !asin_reg && sqrt_root == 32'd0)
            begin
                q_reg[0] <= ONE[31:0];
                q_reg[1] <= 32'sd0;
                q_reg[2] <= 32'sd0;
                q_reg[3] <= 32'sd0;
            end
            if (state_reg == S_DIV && div_done)
            begin
                q_reg[kidx_reg] <= norm_q(div_quo, p_reg[kidx_reg][31]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg.valid)
        begin
            acc_reg[pend_reg.dst] <= acc_sum;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    g_reg[0] <= gyro_x;
                    g_reg[1] <= gyro_y;
                    g_reg[2] <= gyro_z;
                    for (int i = 0; i < 5; i++)
                    begin
                        acc_reg[i] <= '0;
                    end
                    seg_reg  <= SEG_H;
                    uidx_reg <= qau_pkg::U_H_BEG;
                end
            end
            S_MUL:
            begin
                uidx_reg <= uidx_reg + 6'd1;
            end
            S_POST:
            begin
                unique case (seg_reg)
                    SEG_H:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            h_reg[i] <= clamp_h(acc_reg[i]);
                        end
                        for (int i = 0; i < 4; i++)
                        begin
                            acc_reg[i] <= AW'(q_reg[i]) <<< qau_pkg::QFB;
                        end
                        seg_reg  <= SEG_UPD;
                        uidx_reg <= qau_pkg::U_UPD_BEG;
                    end
                    SEG_UPD:
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            p_reg[i] <= clamp_p(acc_reg[i]);
                        end
                        acc_reg[4] <= '0;
                        seg_reg    <= SEG_SQR;
                        uidx_reg   <= qau_pkg::U_SQR_BEG;
                    end
                    SEG_SQR:
                    begin
                        asin_reg <= 1'b0;
                    end
                    SEG_MAT:
                    begin
                        t11_reg <= rnd_mat(acc_reg[0]);
                        t12_reg <= rnd_mat(acc_reg[1] <<< 1);
                        t23_reg <= rnd_mat(acc_reg[3] <<< 1);
                        t33_reg <= rnd_mat(acc_reg[4]);
                        if (rnd_mat(acc_reg[2] <<< 1) > CW'(M_ONE))
                        begin
                            t13_reg <= M_ONE[31:0];
                        end
                        else if (rnd_mat(acc_reg[2] <<< 1) < -CW'(M_ONE))
                        begin
                            t13_reg <= -M_ONE[31:0];
                        end
                        else
                        begin
                            t13_reg <= 32'(rnd_mat(acc_reg[2] <<< 1));
                        end
                        acc_reg[0] <= '0;
                        seg_reg    <= SEG_T13;
                        uidx_reg   <= qau_pkg::U_T13;
                    end
                    SEG_T13:
                    begin
                        asin_reg <= 1'b1;
                    end
                    default:
                    begin
                        seg_reg <= SEG_H;
                    end
                endcase
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    kidx_reg <= 2'd0;
                    if (asin_reg)
                    begin
                        s2_reg <= sqrt_root;
                    end
                    else
                    begin
                        n_reg <= sqrt_root;
                        if (sqrt_root == 32'd0)
                        begin
                            for (int i = 0; i < 5; i++)
                            begin
                                acc_reg[i] <= '0;
                            end
                            seg_reg  <= SEG_MAT;
                            uidx_reg <= qau_pkg::U_MAT_BEG;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    kidx_reg <= kidx_reg + 2'd1;
                    if (kidx_reg == 2'd3)
                    begin
                        for (int i = 0; i < 5; i++)
                        begin
                            acc_reg[i] <= '0;
                        end
                        seg_reg  <= SEG_MAT;
                        uidx_reg <= qau_pkg::U_MAT_BEG;
                    end
                end
            end
            S_CORD:
            begin
                if (cord_done)
                begin
                    kidx_reg <= kidx_reg + 2'd1;
                    unique case (kidx_reg)
                        2'd0:
                        begin
                            yaw_reg <= cord_angle;
                        end
                        2'd1:
                        begin
                            roll_reg <= cord_angle;
                        end
                        default:
                        begin
                            if (pitch_neg > 17'sd16384)
                            begin
                                out_pitch_reg <= 16'sd16384;
                            end
                            else if (pitch_neg < -17'sd16384)
                            begin
                                out_pitch_reg <= -16'sd16384;
                            end
                            else
                            begin
                                out_pitch_reg <= pitch_neg[15:0];
                            end
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        out_q_reg[i] <= q_reg[i];
                    end
                    out_roll_reg <= roll_reg;
                    out_yaw_reg  <= yaw_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // pitch is staged in its output register, so hold it until the beat is loaded
    logic signed [15:0] pitch_hold_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pitch_hold_reg <= out_pitch_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign quat_w      = out_q_reg[0];
    assign quat_x      = out_q_reg[1];
    assign quat_y      = out_q_reg[2];
    assign quat_z      = out_q_reg[3];
    assign roll_angle  = out_roll_reg;
    assign pitch_angle = pitch_hold_reg;
    assign yaw_angle   = out_yaw_reg;

endmodule

`default_nettype wire
